FILE: src/mpca_pkg.sv
// Package for the masked pixel charge accumulator.
// Holds field widths, operation and register codes, the mask table and shared types.
package mpca_pkg;

  localparam int unsigned SUPER_COLUMNS = 16;
  localparam int unsigned PIXELS_PER_SP = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SC_W     = 4;
  localparam int unsigned SP_W     = 4;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CHARGE_W = 10;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned EVENT_W  = 32;
  localparam int unsigned ENTRY_W  = SUM_W + COUNT_W;

  localparam int unsigned CFG_W     = 4;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_STEP   = 1'b1;

  localparam logic [SP_W-1:0]    SP_CENTER = 4'd7;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned MASK_LEN = 16;
  localparam logic [PIX_W-1:0] MASK_POS [MASK_LEN] = '{
    8'd0, 8'd7, 8'd8, 8'd15, 8'd18, 8'd21, 8'd26, 8'd29,
    8'd33, 8'd36, 8'd43, 8'd46, 8'd51, 8'd54, 8'd57, 8'd60
  };

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_HEADER = 2'd0,
    OP_HIT    = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_e;

  typedef struct packed {
    op_e                 kind;
    logic                bad;
    logic                hit;
    logic                rd_en;
    logic [SC_W-1:0]     sc;
    logic [PIX_W-1:0]    pixel;
    logic [CHARGE_W-1:0] charge;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

FILE: src/mpca_if.sv
// Handshake interfaces for the input and result channels of the accumulator.
// Field widths come from mpca_pkg.
interface mpca_in_if;
  logic                              valid;
  logic                              ready;
  logic [mpca_pkg::OP_W-1:0]         operation;
  logic                              bad_event;
  logic [mpca_pkg::SC_W-1:0]         super_column;
  logic [mpca_pkg::SP_W-1:0]         raw_superpixel;
  logic [mpca_pkg::PIX_W-1:0]        pixel_index;
  logic [mpca_pkg::CHARGE_W-1:0]     adc_charge;

  modport source (
    output valid, operation, bad_event, super_column, raw_superpixel, pixel_index,
    adc_charge,
    input  ready
  );
  modport sink (
    input  valid, operation, bad_event, super_column, raw_superpixel, pixel_index,
    adc_charge,
    output ready
  );
endinterface

interface mpca_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit_accepted;
  logic [mpca_pkg::SUM_W-1:0]    charge_sum;
  logic [mpca_pkg::COUNT_W-1:0]  sample_count;
  logic [mpca_pkg::EVENT_W-1:0]  events_seen;
  logic [mpca_pkg::EVENT_W-1:0]  events_corrupted;

  modport source (
    output valid, hit_accepted, charge_sum, sample_count, events_seen, events_corrupted,
    input  ready
  );
  modport sink (
    input  valid, hit_accepted, charge_sum, sample_count, events_seen, events_corrupted,
    output ready
  );
endinterface

FILE: src/mpca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/mpca_front.sv
// Front end: takes input words, holds configuration and the skip flag, classifies hits.
// Depends on mpca_pkg and mpca_in_if.
module mpca_front #(
  parameter int unsigned SuperColumns = mpca_pkg::SUPER_COLUMNS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mpca_in_if.sink                          in_i,
  input  logic                             cfg_we_i,
  input  logic [mpca_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  logic [mpca_pkg::CFG_W-1:0]       cfg_data_i,
  input  mpca_pkg::back_status_t           status_i,
  input  logic                             full_i,
  output logic                             push_o,
  output mpca_pkg::item_t                  item_o
);

  logic [mpca_pkg::SP_W-1:0]  target_q;
  logic [mpca_pkg::CFG_W-1:0] step_q;
  logic                       skip_q;

  mpca_pkg::op_e              op;
  logic                       sc_ok;
  logic [mpca_pkg::SP_W-1:0]  sp;
  logic [mpca_pkg::PIX_W-1:0] mapped;
  logic [mpca_pkg::PIX_W-1:0] shift;
  logic                       in_mask;

  assign in_i.ready = !status_i.clearing && !full_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    op     = mpca_pkg::op_e'(in_i.operation);
    sc_ok  = 7'(in_i.super_column) < 7'(SuperColumns);
    sp     = (in_i.raw_superpixel >= mpca_pkg::SP_CENTER) ?
             in_i.raw_superpixel - mpca_pkg::SP_CENTER :
             mpca_pkg::SP_CENTER - in_i.raw_superpixel;
    mapped = {~in_i.pixel_index[7:4], in_i.pixel_index[3:0]};
    shift  = {step_q, 4'b0000};
    in_mask = 1'b0;
    for (int k = 0; k < mpca_pkg::MASK_LEN; k++) begin
      if (8'(mpca_pkg::MASK_POS[k] + shift) == mapped) begin
        in_mask = 1'b1;
      end
    end
  end

  always_comb begin
    item_o.kind   = op;
    item_o.bad    = in_i.bad_event;
    item_o.sc     = in_i.super_column;
    item_o.charge = in_i.adc_charge;
    item_o.pixel  = in_i.pixel_index;
    item_o.hit    = 1'b0;
    item_o.rd_en  = 1'b0;
    case (op)
      mpca_pkg::OP_HIT: begin
        item_o.pixel = mapped;
        item_o.hit   = !skip_q && sc_ok && (sp == target_q) && in_mask;
      end
      mpca_pkg::OP_READ: begin
        item_o.rd_en = sc_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      step_q   <= '0;
      skip_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mpca_pkg::REG_TARGET: target_q <= cfg_data_i;
          mpca_pkg::REG_STEP:   step_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (push_o && op == mpca_pkg::OP_HEADER) begin
        skip_q <= in_i.bad_event;
      end
    end
  end

endmodule

FILE: src/mpca_queue.sv
// Short queue of classified items between front end and back end.
// Depends on mpca_pkg.
module mpca_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mpca_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mpca_pkg::item_t head_o
);

  localparam int unsigned Depth = mpca_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);

  mpca_pkg::item_t  slots_q [Depth];
  logic [PtrW-1:0]  wptr_q;
  logic [PtrW-1:0]  rptr_q;
  logic [PtrW:0]    count_q;

  assign full_o  = count_q == (PtrW+1)'(Depth);
  assign valid_o = count_q != '0;
  assign head_o  = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");
`endif

endmodule

FILE: src/mpca_back.sv
// Back end: clears the store after reset, runs read-modify-write on hits, reads entries,
// keeps the event counters and the result register. Depends on mpca_pkg, mpca_out_if,
// mpca_ram.
module mpca_back #(
  parameter int unsigned SuperColumns = mpca_pkg::SUPER_COLUMNS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  mpca_pkg::item_t        head_i,
  output logic                   pop_o,
  output mpca_pkg::back_status_t status_o,
  mpca_out_if.source             out_o
);

  localparam int unsigned Depth = SuperColumns * mpca_pkg::PIXELS_PER_SP;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned WideW = AddrW + mpca_pkg::SC_W + mpca_pkg::PIX_W;

  function automatic logic [AddrW-1:0] addr_of(logic [mpca_pkg::SC_W-1:0]  sc,
                                               logic [mpca_pkg::PIX_W-1:0] pix);
    logic [WideW-1:0] wide;
    wide = WideW'({sc, pix});
    return wide[AddrW-1:0];
  endfunction

  mpca_pkg::state_e st_q, st_d;
  logic [AddrW-1:0] clr_q;
  mpca_pkg::item_t  cur_q;
  logic [mpca_pkg::EVENT_W-1:0] ev_q;
  logic [mpca_pkg::EVENT_W-1:0] cor_q;
  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [mpca_pkg::SUM_W-1:0]   out_sum_q;
  logic [mpca_pkg::COUNT_W-1:0] out_cnt_q;

  logic                          start;
  logic                          load;
  logic                          ram_we;
  logic                          ram_re;
  logic [AddrW-1:0]              ram_waddr;
  logic [mpca_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [mpca_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [mpca_pkg::SUM_W-1:0]    rd_sum;
  logic [mpca_pkg::COUNT_W-1:0]  rd_cnt;
  logic [mpca_pkg::SUM_W:0]      sum_ext;
  logic [mpca_pkg::SUM_W-1:0]    sum_new;
  logic [mpca_pkg::COUNT_W-1:0]  cnt_new;

  mpca_ram #(
    .Width (mpca_pkg::ENTRY_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_of(head_i.sc, head_i.pixel)),
    .rdata_o (ram_rdata)
  );

  assign start = head_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    rd_sum  = ram_rdata[mpca_pkg::SUM_W-1:0];
    rd_cnt  = ram_rdata[mpca_pkg::ENTRY_W-1:mpca_pkg::SUM_W];
    sum_ext = (mpca_pkg::SUM_W+1)'(rd_sum) + (mpca_pkg::SUM_W+1)'(cur_q.charge);
    sum_new = sum_ext[mpca_pkg::SUM_W] ? mpca_pkg::SUM_MAX : sum_ext[mpca_pkg::SUM_W-1:0];
    cnt_new = (rd_cnt == mpca_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      mpca_pkg::ST_CLEAR: begin
        if (clr_q == AddrW'(Depth - 1)) begin
          st_d = mpca_pkg::ST_IDLE;
        end
      end
      mpca_pkg::ST_IDLE: begin
        if (start) begin
          st_d = mpca_pkg::ST_ACCESS;
        end
      end
      mpca_pkg::ST_ACCESS: st_d = mpca_pkg::ST_IDLE;
      default: st_d = mpca_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    pop_o             = 1'b0;
    ram_re            = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = addr_of(cur_q.sc, cur_q.pixel);
    ram_wdata         = {cnt_new, sum_new};
    load              = 1'b0;
    status_o.clearing = 1'b0;
    case (st_q)
      mpca_pkg::ST_CLEAR: begin
        ram_we            = 1'b1;
        ram_waddr         = clr_q;
        ram_wdata         = '0;
        status_o.clearing = 1'b1;
      end
      mpca_pkg::ST_IDLE: begin
        pop_o  = start;
        ram_re = start;
      end
      mpca_pkg::ST_ACCESS: begin
        ram_we = cur_q.hit;
        load   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (load) begin
      out_hit_q <= cur_q.hit;
      out_sum_q <= cur_q.rd_en ? rd_sum : '0;
      out_cnt_q <= cur_q.rd_en ? rd_cnt : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mpca_pkg::ST_CLEAR;
      clr_q       <= '0;
      ev_q        <= '0;
      cor_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == mpca_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (load && cur_q.kind == mpca_pkg::OP_HEADER) begin
        ev_q <= ev_q + 1'b1;
        if (cur_q.bad) begin
          cor_q <= cor_q + 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.hit_accepted     = out_hit_q;
  assign out_o.charge_sum       = out_sum_q;
  assign out_o.sample_count     = out_cnt_q;
  assign out_o.events_seen      = ev_q;
  assign out_o.events_corrupted = cor_q;

`ifndef ASSERT_OFF
  a_slot_free_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !out_valid_q)
    else $error("result register overwritten before it was taken");
  a_corrupt_with_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_q != $past(cor_q) |-> ev_q != $past(ev_q))
    else $error("corrupted count moved without event count");
  a_result_from_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == mpca_pkg::ST_ACCESS)
    else $error("result word raised outside the access step");
  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(ev_q) && $stable(cor_q))
    else $error("counters changed under a waiting result word");
`endif

endmodule

FILE: src/masked_pixel_charge_accumulator.sv
// An accepted input word waits in the queue; the back end then reads its store entry,
// writes it back on a hit and registers the result word, and takes no new word until
// that read-then-write is done. Up to two accepted words wait in the queue while the
// result register is stalled. Reset clears counters and registers at once; the store
// of SuperColumns*256 entries (4096 by default) is then cleared, and meanwhile no input
// word is taken. Depends on mpca_pkg, mpca_if, mpca_front, mpca_queue and mpca_back.
module masked_pixel_charge_accumulator #(
  parameter int unsigned SuperColumns = mpca_pkg::SUPER_COLUMNS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mpca_in_if.sink                        in_i,
  mpca_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [mpca_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [mpca_pkg::CFG_W-1:0]     cfg_data_i
);

  mpca_pkg::back_status_t status;
  mpca_pkg::item_t        push_item;
  mpca_pkg::item_t        head_item;
  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   head_valid;

  mpca_front #(
    .SuperColumns (SuperColumns)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  mpca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_item)
  );

  mpca_back #(
    .SuperColumns (SuperColumns)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .status_o     (status),
    .out_o        (out_o)
  );

endmodule

FILE: test/tb_top.sv
// Testbench for masked_pixel_charge_accumulator: directed cases, back-pressure and random
// traffic, each result word checked against an in-bench model of the store and counters.
// Depends on mpca_pkg, the mpca_in_if / mpca_out_if interfaces and masked_pixel_charge_accumulator.
`timescale 1ns / 1ps

module tb_top;
  import mpca_pkg::*;

  typedef struct packed {
    op_e                 op;
    logic                bad;
    logic [SC_W-1:0]     sc;
    logic [SP_W-1:0]     rsp;
    logic [PIX_W-1:0]    pix;
    logic [CHARGE_W-1:0] charge;
  } pixel_word_t;

  typedef struct packed {
    logic                accepted;
    logic [SUM_W-1:0]    sum;
    logic [COUNT_W-1:0]  count;
    logic [EVENT_W-1:0]  seen;
    logic [EVENT_W-1:0]  corrupted;
  } tally_t;

  localparam int unsigned STORE_DEPTH = SUPER_COLUMNS * PIXELS_PER_SP;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  mpca_in_if in_if ();
  mpca_out_if out_if ();

  masked_pixel_charge_accumulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  logic [SUM_W-1:0]   charge_sums [STORE_DEPTH];
  logic [COUNT_W-1:0] hit_counts [STORE_DEPTH];
  logic [EVENT_W-1:0] headers_seen;
  logic [EVENT_W-1:0] headers_corrupted;
  logic               skip_hits;
  logic [SP_W-1:0]    target_sp;
  logic [3:0]         mask_step_cfg;

  tally_t      expected_tallies [$];
  int unsigned filled_entries [$];
  int unsigned mismatches = 0;
  int unsigned ready_hold_cycles = 0;
  bit          idle_enable = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic tally_t predict_tally(input pixel_word_t w);
    tally_t r;
    logic [SP_W-1:0] sp;
    logic [PIX_W-1:0] mapped;
    logic [PIX_W-1:0] step_offset;
    logic [SUM_W:0] wide_sum;
    int unsigned entry;
    bit in_mask;
    r = '0;
    in_mask = 1'b0;
    step_offset = {mask_step_cfg, 4'd0};
    case (w.op)
      OP_HEADER: begin
        headers_seen = headers_seen + 1'b1;
        if (w.bad) headers_corrupted = headers_corrupted + 1'b1;
        skip_hits = w.bad;
      end
      OP_HIT: begin
        sp = (w.rsp >= SP_CENTER) ? w.rsp - SP_CENTER : SP_CENTER - w.rsp;
        mapped = {4'd15 - w.pix[7:4], w.pix[3:0]};
        for (int k = 0; k < MASK_LEN; k++) begin
          if (PIX_W'(MASK_POS[k] + step_offset) == mapped) in_mask = 1'b1;
        end
        if (!skip_hits && w.sc < SUPER_COLUMNS && sp == target_sp && in_mask) begin
          entry = w.sc * PIXELS_PER_SP + mapped;
          wide_sum = charge_sums[entry] + w.charge;
          charge_sums[entry] = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
          if (hit_counts[entry] != COUNT_MAX) hit_counts[entry] = hit_counts[entry] + 1'b1;
          filled_entries.insert(filled_entries.size(), entry);
          r.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (w.sc < SUPER_COLUMNS) begin
          entry = w.sc * PIXELS_PER_SP + w.pix;
          r.sum = charge_sums[entry];
          r.count = hit_counts[entry];
        end
      end
      default: begin
      end
    endcase
    r.seen = headers_seen;
    r.corrupted = headers_corrupted;
    return r;
  endfunction

  function automatic pixel_word_t noise_word();
    pixel_word_t w;
    w.op = op_e'($urandom_range(0, 3));
    w.bad = 1'($urandom_range(0, 1));
    w.sc = SC_W'($urandom_range(0, (1 << SC_W) - 1));
    w.rsp = SP_W'($urandom_range(0, (1 << SP_W) - 1));
    w.pix = PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
    w.charge = CHARGE_W'($urandom_range(0, (1 << CHARGE_W) - 1));
    return w;
  endfunction

  function automatic logic [SP_W-1:0] raw_superpixel_for(input logic [SP_W-1:0] t);
    if (t == 0) return SP_CENTER;
    if (t > 8) return SP_W'($urandom_range(0, (1 << SP_W) - 1));
    if (t == 8 || $urandom_range(0, 1)) return SP_CENTER + t;
    return SP_CENTER - t;
  endfunction

  function automatic logic [PIX_W-1:0] raw_pixel_for(input int unsigned k,
                                                      input logic [3:0] step);
    logic [PIX_W-1:0] mapped;
    mapped = MASK_POS[k] + {step, 4'd0};
    return {4'd15 - mapped[7:4], mapped[3:0]};
  endfunction

  function automatic pixel_word_t hit_candidate();
    pixel_word_t w;
    w = noise_word();
    w.op = OP_HIT;
    if ($urandom_range(0, 4) != 0) begin
      w.rsp = raw_superpixel_for(target_sp);
      w.pix = raw_pixel_for($urandom_range(0, MASK_LEN - 1), mask_step_cfg);
    end
    return w;
  endfunction

  function automatic pixel_word_t read_candidate();
    pixel_word_t w;
    int unsigned entry;
    w = noise_word();
    w.op = OP_READ;
    if (filled_entries.size() != 0 && $urandom_range(0, 3) != 0) begin
      entry = filled_entries[$urandom_range(0, filled_entries.size() - 1)];
      w.sc = SC_W'(entry / PIXELS_PER_SP);
      w.pix = PIX_W'(entry % PIXELS_PER_SP);
    end
    return w;
  endfunction

  task automatic send_word(input pixel_word_t w);
    int unsigned gap;
    tally_t want;
    gap = idle_enable ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.operation <= w.op;
    in_if.bad_event <= w.bad;
    in_if.super_column <= w.sc;
    in_if.raw_superpixel <= w.rsp;
    in_if.pixel_index <= w.pix;
    in_if.adc_charge <= w.charge;
    do @(posedge clk_i); while (!in_if.ready);
    want = predict_tally(w);
    expected_tallies.insert(expected_tallies.size(), want);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mask_config(input logic [SP_W-1:0] t, input logic [3:0] s);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_TARGET;
    cfg_data_i <= t;
    @(posedge clk_i);
    cfg_index_i <= REG_STEP;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    target_sp = t;
    mask_step_cfg = s;
    @(posedge clk_i);
  endtask

  initial begin : result_receiver
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (ready_hold_cycles != 0) begin
        stall = ready_hold_cycles;
        ready_hold_cycles = 0;
      end else begin
        stall = idle_enable ? $urandom_range(0, 6) : 0;
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tallies.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_tallies.pop_front();
        if (out_if.hit_accepted !== want.accepted) begin
          $error("hit_accepted: expected %0d, got %0d", want.accepted, out_if.hit_accepted);
          mismatches++;
        end
        if (out_if.charge_sum !== want.sum) begin
          $error("charge_sum: expected %0d, got %0d", want.sum, out_if.charge_sum);
          mismatches++;
        end
        if (out_if.sample_count !== want.count) begin
          $error("sample_count: expected %0d, got %0d", want.count, out_if.sample_count);
          mismatches++;
        end
        if (out_if.events_seen !== want.seen) begin
          $error("events_seen: expected %0d, got %0d", want.seen, out_if.events_seen);
          mismatches++;
        end
        if (out_if.events_corrupted !== want.corrupted) begin
          $error("events_corrupted: expected %0d, got %0d", want.corrupted,
                 out_if.events_corrupted);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_and_config();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      charge_sums[i] = '0;
      hit_counts[i] = '0;
    end
    headers_seen = '0;
    headers_corrupted = '0;
    skip_hits = 1'b0;
    target_sp = '0;
    mask_step_cfg = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_TARGET;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.operation <= OP_NONE;
    in_if.bad_event <= 1'b0;
    in_if.super_column <= '0;
    in_if.raw_superpixel <= '0;
    in_if.pixel_index <= '0;
    in_if.adc_charge <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mask_config(4'd0, 4'd0);
  endtask

  task automatic test_directed_cases();
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd7, 8'hF0, 10'd1023});
    send_word('{OP_READ, 1'b0, 4'd0, 4'd0, 8'h00, 10'd0});
    send_word('{OP_HEADER, 1'b0, 4'd0, 4'd0, 8'h00, 10'd0});
    send_word('{OP_HIT, 1'b0, 4'd15, 4'd7, 8'hCC, 10'd0});
    send_word('{OP_HIT, 1'b0, 4'd15, 4'd7, 8'hF1, 10'd5});
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd0, 8'hF0, 10'd9});
    send_word('{OP_HEADER, 1'b1, 4'd15, 4'd15, 8'hFF, 10'd1023});
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd7, 8'hF0, 10'd100});
    send_word('{OP_READ, 1'b1, 4'd15, 4'd15, 8'h3C, 10'd1023});
    send_word('{OP_NONE, 1'b1, 4'd15, 4'd15, 8'hFF, 10'd1023});
    send_word('{OP_HEADER, 1'b0, 4'd0, 4'd0, 8'h00, 10'd0});
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd7, 8'hF0, 10'd1023});
    send_word('{OP_READ, 1'b0, 4'd0, 4'd0, 8'h00, 10'd0});
    send_word('{OP_READ, 1'b0, 4'd15, 4'd0, 8'hFF, 10'd0});
  endtask

  task automatic test_target_extremes();
    set_mask_config(4'd8, 4'd15);
    send_word('{OP_HIT, 1'b0, 4'd3, 4'd15, 8'h00, 10'd512});
    send_word('{OP_HIT, 1'b0, 4'd3, 4'd15, 8'hDC, 10'd1});
    send_word('{OP_READ, 1'b0, 4'd3, 4'd0, 8'hF0, 10'd0});
    send_word('{OP_READ, 1'b0, 4'd3, 4'd0, 8'h2C, 10'd0});
    set_mask_config(4'd15, 4'd0);
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd15, 8'hF0, 10'd7});
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd0, 8'hF0, 10'd7});
    set_mask_config(4'd7, 4'd0);
    send_word('{OP_HIT, 1'b0, 4'd0, 4'd0, 8'hF0, 10'd3});
    send_word('{OP_READ, 1'b0, 4'd0, 4'd0, 8'h00, 10'd0});
  endtask

  task automatic test_backpressure();
    set_mask_config(4'd2, 4'd9);
    idle_enable = 1'b0;
    ready_hold_cycles = 80;
    repeat (24) send_word(hit_candidate());
    wait_drained();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_traffic(input logic [SP_W-1:0] t, input logic [3:0] s,
                                     input int unsigned word_total, input bit idle);
    pixel_word_t w;
    int unsigned sent;
    int unsigned burst;
    set_mask_config(t, s);
    idle_enable = idle;
    sent = 0;
    while (sent < word_total) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(noise_word());
        sent++;
      end else begin
        w = noise_word();
        w.op = OP_HEADER;
        w.bad = ($urandom_range(0, 4) == 0);
        send_word(w);
        sent++;
        burst = $urandom_range(1, 6);
        repeat (burst) send_word(hit_candidate());
        sent += burst;
        burst = $urandom_range(0, 2);
        repeat (burst) send_word(read_candidate());
        sent += burst;
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    test_reset_and_config();
    test_directed_cases();
    test_target_extremes();
    test_backpressure();
    test_random_traffic(4'd3, 4'd5, 70, 1'b1);
    test_random_traffic(4'd8, 4'd0, 70, 1'b0);
    test_random_traffic(4'd0, 4'd15, 70, 1'b1);
    test_random_traffic(4'd15, 4'd7, 70, 1'b1);
    test_random_traffic(SP_W'($urandom_range(0, 8)), 4'($urandom_range(0, 15)), 70, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: masked_pixel_charge_accumulator.f
src/mpca_pkg.sv
src/mpca_if.sv
src/mpca_ram.sv
src/mpca_front.sv
src/mpca_queue.sv
src/mpca_back.sv
src/masked_pixel_charge_accumulator.sv
test/tb_top.sv
